// File: rtl/vehicle_drive_step_assert.svh
// Assertion macros for the vehicle drive step block.
`ifndef VEHICLE_DRIVE_STEP_ASSERT_SVH
`define VEHICLE_DRIVE_STEP_ASSERT_SVH
`ifndef ASSERT_OFF
`define VDS_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("vehicle_drive_step check failed");
`define VDS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("vehicle_drive_step sequence check failed");
`else
`define VDS_ASSERT(label, cond)
`define VDS_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: rtl/vds_pkg.sv
// Shared constants, types and tables for the vehicle drive step block.
`timescale 1ns / 1ps
`default_nettype none
package vds_pkg;
  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int DIV_NUM_W = 58;
  localparam int DIV_DEN_W = 42;

  localparam logic [1:0] REQ_CONTROL = 2'd0;
  localparam logic [1:0] REQ_GEAR    = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;
  // Request code with no meaning; such a transaction is dropped.
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  localparam logic [1:0] GEAR_PARK    = 2'd0;
  localparam logic [1:0] GEAR_NEUTRAL = 2'd1;
  localparam logic [1:0] GEAR_DRIVE   = 2'd2;
  localparam logic [1:0] GEAR_REVERSE = 2'd3;

  localparam logic [2:0] REG_ACCEL_LIMIT = 3'd0;
  localparam logic [2:0] REG_BRAKE_LIMIT = 3'd1;
  localparam logic [2:0] REG_STEER_LIMIT = 3'd2;
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd3;
  localparam logic [2:0] REG_AXLE_DIST   = 3'd4;

  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [27:0] START_VEC   = 28'sd16777216;

  // Divider handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Arctangent of 2^-i in Q.30, truncated.
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] r;
    unique case (idx)
      5'd0:  r = 30'd843314856;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;
      5'd21: r = 30'd511;
      5'd22: r = 30'd255;
      5'd23: r = 30'd127;
      default: r = 30'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// File: rtl/vds_div.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module vds_div #(
  parameter int NUM_W = 58,
  parameter int DEN_W = 42
) (
  input  wire                     clk,
  input  wire                     rst,
  input  vds_pkg::div_ctrl_t      ctrl,
  input  wire  [NUM_W-1:0]        num,
  input  wire  [DEN_W-1:0]        den,
  output vds_pkg::div_stat_t      stat,
  output logic [NUM_W-1:0]        quot
);
  import vds_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] NUM_CNT = CNT_W'(NUM_W);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dr;
  logic [NUM_W-1:0] qr;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   diff;

  // One trial subtraction per cycle.
  assign rem_sh = {rem, qr[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dr};
  assign diff   = rem_sh - {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !busy) begin
        busy <= 1'b1;
        cnt  <= NUM_CNT;
        rem  <= '0;
        dr   <= den;
        qr   <= num;
      end else if (busy) begin
        rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        qr  <= {qr[NUM_W-2:0], ge};
        cnt <= cnt - ONE_CNT;
        if (cnt == ONE_CNT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = qr;
endmodule
`default_nettype wire

// File: rtl/vehicle_drive_step.sv
// Vehicle drive step: gear split, brake limit, speed integration and steering geometry.
// Input channel (in_valid/in_stall) carries control, gear and tick requests.
// Control and gear requests update stored targets and give no result.
// A tick runs one kinematic step and gives one result on the output channel
// (out_valid/out_stall). The block stalls its input until that result is taken.
// A tick uses the shared divider for three divisions (brake limit, turn radius,
// heading rate), and the CORDIC tangent does one rotation step per cycle.
// A zero time step skips the brake division; a straight wheel skips the tangent
// and both geometry divisions; a zero sine skips the turn-radius division and a
// zero cosine skips the heading-rate division. The next transaction is taken in
// the cycle after the result leaves.
// The result is held stable while out_stall is high; no new item is taken then.
// Configuration writes (write_en, write_index, write_data) must be made while the
// block is idle; the block itself does not enforce this. Synchronous reset restores
// the register defaults, selects drive, and clears the targets and the speed state.
`timescale 1ns / 1ps
`default_nettype none
module vehicle_drive_step #(
  parameter int ANGLE_ITERATIONS = vds_pkg::ANGLE_ITERATIONS_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire         [1:0]  req_type,
  input  wire  signed [15:0] target_accel,
  input  wire  signed [15:0] target_steer,
  input  wire         [1:0]  gear_cmd,
  input  wire         [15:0] step_time,
  input  wire  signed [15:0] measured_speed,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [15:0] speed_out,
  output logic signed [16:0] accel_out,
  output logic signed [15:0] steer_out,
  output logic signed [23:0] turn_radius,
  output logic signed [15:0] yaw_rate,
  output logic        [1:0]  gear_out,
  input  wire                write_en,
  input  wire         [2:0]  write_index,
  input  wire         [15:0] write_data
);
  import vds_pkg::*;

  localparam int ITER_W = $clog2(ANGLE_ITERATIONS);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ANGLE_ITERATIONS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BDIV  = 4'd1;
  localparam logic [3:0] S_BWAIT = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_SPD   = 4'd5;
  localparam logic [3:0] S_CORD  = 4'd6;
  localparam logic [3:0] S_PRODC = 4'd7;
  localparam logic [3:0] S_PRODS = 4'd8;
  localparam logic [3:0] S_RDIV  = 4'd9;
  localparam logic [3:0] S_RWAIT = 4'd10;
  localparam logic [3:0] S_HDIV  = 4'd11;
  localparam logic [3:0] S_HWAIT = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state;

  // Configuration and stored state.
  logic        [14:0] accel_limit;
  logic        [14:0] brake_limit;
  logic        [14:0] steer_limit;
  logic        [14:0] speed_limit;
  logic        [15:0] axle_dist;
  logic        [1:0]  gear_state;
  logic signed [15:0] accel_target;
  logic signed [15:0] steer_target;
  logic signed [15:0] speed_state;

  // Per-tick working registers.
  logic        [15:0] dt_r;
  logic signed [15:0] v_r;
  logic signed [16:0] drv_r;
  logic        [15:0] brk_r;
  logic        [14:0] lim_r;
  logic signed [16:0] acc_r;
  logic signed [15:0] steer_r;
  logic signed [33:0] prod_r;
  logic signed [27:0] x_r;
  logic signed [27:0] y_r;
  logic signed [33:0] ang_r;
  logic [ITER_W-1:0]  cnt;
  logic signed [44:0] wc_r;
  logic signed [43:0] ss_r;
  logic signed [23:0] rad_r;
  logic signed [15:0] hr_r;

  // Divider interface.
  div_ctrl_t              div_ctrl;
  div_stat_t              div_stat;
  logic [DIV_NUM_W-1:0]   div_num;
  logic [DIV_DEN_W-1:0]   div_den;
  logic [DIV_NUM_W-1:0]   div_quot;

  vds_div #(
    .NUM_W(DIV_NUM_W),
    .DEN_W(DIV_DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .num  (div_num),
    .den  (div_den),
    .stat (div_stat),
    .quot (div_quot)
  );

  assign div_ctrl.start = (state == S_BDIV) || (state == S_RDIV && y_r != 28'sd0) ||
                          (state == S_HDIV && x_r != 28'sd0);

  // Operand selection for the shared divider.
  logic        [16:0] av;
  logic signed [44:0] wc_abs;
  logic signed [27:0] y_abs;
  logic signed [43:0] ss_abs;
  assign av     = v_r[15] ? 17'(-$signed({v_r[15], v_r})) : {1'b0, v_r};
  assign wc_abs = wc_r[44] ? -wc_r : wc_r;
  assign y_abs  = y_r[27] ? -y_r : y_r;
  assign ss_abs = ss_r[43] ? -ss_r : ss_r;

  always_comb begin
    div_num = '0;
    div_den = '0;
    priority case (state)
      S_BDIV: begin
        div_num = DIV_NUM_W'({av, 16'd0});
        div_den = DIV_DEN_W'(dt_r);
      end
      S_RDIV: begin
        div_num = DIV_NUM_W'(wc_abs[41:0]);
        div_den = DIV_DEN_W'({y_abs[25:0], 4'd0});
      end
      default: begin
        div_num = DIV_NUM_W'({ss_abs[41:0], 16'd0});
        div_den = wc_abs[41:0];
      end
    endcase
  end

  // Gear split of the stored target acceleration.
  logic signed [16:0] a_ext;
  logic signed [16:0] drv_split;
  logic        [15:0] brk_split;
  logic signed [16:0] a_neg;
  assign a_ext = 17'(accel_target);
  assign a_neg = -a_ext;

  always_comb begin
    unique case (gear_state)
      GEAR_DRIVE: begin
        drv_split = accel_target > 16'sd0 ? a_ext : 17'sd0;
        brk_split = accel_target < 16'sd0 ? a_neg[15:0] : 16'd0;
      end
      GEAR_REVERSE: begin
        drv_split = accel_target < 16'sd0 ? a_ext : 17'sd0;
        brk_split = accel_target > 16'sd0 ? a_ext[15:0] : 16'd0;
      end
      GEAR_PARK: begin
        drv_split = 17'sd0;
        brk_split = {1'b0, brake_limit};
      end
      default: begin
        drv_split = 17'sd0;
        brk_split = 16'd0;
      end
    endcase
  end

  // Clamping of drive, brake and steer.
  logic        [15:0] brk_c;
  logic signed [16:0] brk_s;
  logic signed [16:0] drv_c;
  logic signed [16:0] ma;
  logic signed [15:0] ms_steer;
  logic signed [15:0] steer_c;
  assign brk_c    = brk_r > {1'b0, lim_r} ? {1'b0, lim_r} : brk_r;
  assign brk_s    = v_r[15] ? $signed({1'b0, brk_c}) : -$signed({1'b0, brk_c});
  assign ma       = $signed({2'b0, accel_limit});
  assign drv_c    = drv_r > ma ? ma : (drv_r < -ma ? -ma : drv_r);
  assign ms_steer = $signed({1'b0, steer_limit});
  assign steer_c  = steer_target > ms_steer ? ms_steer :
                    (steer_target < -ms_steer ? -ms_steer : steer_target);

  // Speed integration with round to nearest.
  logic signed [33:0] p_round;
  logic signed [18:0] spd_sum;
  logic signed [18:0] msp;
  logic signed [18:0] spd_c;
  assign p_round = prod_r + 34'sd32768;
  assign spd_sum = 19'(speed_state) + 19'(p_round >>> 16);
  assign msp     = $signed({4'b0, speed_limit});
  assign spd_c   = spd_sum > msp ? msp : (spd_sum < -msp ? -msp : spd_sum);

  // CORDIC start vector with the half-turn fold.
  logic signed [33:0] ang0;
  logic               straight;
  assign ang0     = $signed({steer_r, 16'd0}) <<< 2 >>> 2;
  assign straight = (steer_r > -16'sd16) && (steer_r < 16'sd16);

  // One CORDIC rotation per cycle.
  logic signed [27:0] dx;
  logic signed [27:0] dy;
  logic signed [33:0] at;
  assign dx = y_r >>> cnt;
  assign dy = x_r >>> cnt;
  assign at = $signed({4'b0, atan_q30(5'(cnt))});

  logic signed [16:0] w_s;
  assign w_s = (axle_dist == 16'd0) ? 17'sd1 : $signed({1'b0, axle_dist});

  // Post-processing of the divider quotients.
  logic               rad_neg;
  logic               hr_neg;
  logic signed [23:0] rad_q;
  logic signed [15:0] hr_q;
  assign rad_neg = wc_r[44] ^ y_r[27];
  assign hr_neg  = ss_r[43] ^ wc_r[44];

  always_comb begin
    if (rad_neg) begin
      if (div_quot > DIV_NUM_W'(8388608)) rad_q = -24'sd8388608;
      else if (div_quot == '0) rad_q = -24'sd1;
      else rad_q = -$signed(div_quot[23:0]);
    end else begin
      if (div_quot > DIV_NUM_W'(8388607)) rad_q = 24'sd8388607;
      else if (div_quot == '0) rad_q = 24'sd1;
      else rad_q = $signed(div_quot[23:0]);
    end
    if (hr_neg) begin
      if (div_quot > DIV_NUM_W'(32768)) hr_q = -16'sd32768;
      else hr_q = -$signed(div_quot[15:0]);
    end else begin
      if (div_quot > DIV_NUM_W'(32767)) hr_q = 16'sd32767;
      else hr_q = $signed(div_quot[15:0]);
    end
  end

  // Sequencer, stored state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      accel_limit  <= 15'd768;
      brake_limit  <= 15'd1536;
      steer_limit  <= 15'd9830;
      speed_limit  <= 15'd5120;
      axle_dist    <= 16'd11469;
      gear_state   <= GEAR_DRIVE;
      accel_target <= '0;
      steer_target <= '0;
      speed_state  <= '0;
      cnt          <= '0;
    end else begin
      if (write_en) begin
        unique case (write_index)
          REG_ACCEL_LIMIT: accel_limit <= write_data[14:0];
          REG_BRAKE_LIMIT: brake_limit <= write_data[14:0];
          REG_STEER_LIMIT: steer_limit <= write_data[14:0];
          REG_SPEED_LIMIT: speed_limit <= write_data[14:0];
          REG_AXLE_DIST:   axle_dist   <= write_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (req_type)
              REQ_CONTROL: begin
                accel_target <= target_accel;
                steer_target <= target_steer;
              end
              REQ_GEAR: gear_state <= gear_cmd;
              REQ_TICK: begin
                dt_r  <= step_time;
                v_r   <= measured_speed;
                drv_r <= drv_split;
                brk_r <= brk_split;
                lim_r <= brake_limit;
                state <= (step_time != 16'd0) ? S_BDIV : S_ACC;
              end
              default: ;
            endcase
          end
        end
        S_BDIV: state <= S_BWAIT;
        S_BWAIT: begin
          if (div_stat.done) begin
            if (div_quot < DIV_NUM_W'(lim_r)) lim_r <= div_quot[14:0];
            state <= S_ACC;
          end
        end
        S_ACC: begin
          acc_r   <= drv_c + brk_s;
          steer_r <= steer_c;
          state   <= S_MUL;
        end
        S_MUL: begin
          prod_r <= acc_r * $signed({1'b0, dt_r});
          state  <= S_SPD;
        end
        S_SPD: begin
          speed_state <= spd_c[15:0];
          cnt         <= '0;
          y_r         <= '0;
          if (ang0 > HALF_PI_Q30) begin
            ang_r <= ang0 - PI_Q30;
            x_r   <= -START_VEC;
          end else if (ang0 < -HALF_PI_Q30) begin
            ang_r <= ang0 + PI_Q30;
            x_r   <= -START_VEC;
          end else begin
            ang_r <= ang0;
            x_r   <= START_VEC;
          end
          if (straight) begin
            rad_r <= '0;
            hr_r  <= '0;
            state <= S_OUT;
          end else begin
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (ang_r >= 34'sd0) begin
            x_r   <= x_r - dx;
            y_r   <= y_r + dy;
            ang_r <= ang_r - at;
          end else begin
            x_r   <= x_r + dx;
            y_r   <= y_r - dy;
            ang_r <= ang_r + at;
          end
          cnt <= cnt + ITER_W'(1);
          if (cnt == ITER_LAST) state <= S_PRODC;
        end
        S_PRODC: begin
          wc_r  <= w_s * x_r;
          state <= S_PRODS;
        end
        S_PRODS: begin
          ss_r  <= speed_state * y_r;
          state <= S_RDIV;
        end
        S_RDIV: begin
          if (y_r == 28'sd0) begin
            rad_r <= x_r[27] ? -24'sd8388608 : 24'sd8388607;
            state <= S_HDIV;
          end else begin
            state <= S_RWAIT;
          end
        end
        S_RWAIT: begin
          if (div_stat.done) begin
            rad_r <= rad_q;
            state <= S_HDIV;
          end
        end
        S_HDIV: begin
          if (x_r == 28'sd0) begin
            hr_r  <= (ss_r == 44'sd0) ? 16'sd0 : (ss_r[43] ? -16'sd32768 : 16'sd32767);
            state <= S_OUT;
          end else begin
            state <= S_HWAIT;
          end
        end
        S_HWAIT: begin
          if (div_stat.done) begin
            hr_r  <= hr_q;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output channel.
  assign in_stall     = (state != S_IDLE);
  assign out_valid    = (state == S_OUT);
  assign speed_out    = speed_state;
  assign accel_out    = acc_r;
  assign steer_out    = steer_r;
  assign turn_radius  = rad_r;
  assign yaw_rate     = hr_r;
  assign gear_out     = gear_state;

  // Terms used by the checks below.
  logic div_wait;
  logic tick_accept;
  assign div_wait    = (state == S_BWAIT) || (state == S_RWAIT) || (state == S_HWAIT);
  assign tick_accept = in_valid && !in_stall && (req_type == REQ_TICK);

  `include "vehicle_drive_step_assert.svh"

  `VDS_ASSERT(a_stall_with_result, !out_valid || in_stall)
  `VDS_ASSERT(a_straight_no_yaw, !(out_valid && turn_radius == 24'sd0) || yaw_rate == 16'sd0)
  `VDS_ASSERT(a_div_done_waited, !div_stat.done || div_wait)
  `VDS_ASSERT(a_div_free_at_start, !div_ctrl.start || !div_stat.busy)
  `VDS_ASSERT_NEXT(a_tick_busy, tick_accept, in_stall && !out_valid)
endmodule
`default_nettype wire
